@@ rtl/mgt_pkg.sv @@
// Shared types and codes for the multiset gcd tracker.
package mgt_pkg;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;   // clear one entry of both stores
    logic load;       // capture the incoming word
    logic cnt_rd;     // read the copy count of the captured value
    logic cnt_eval;   // update the count and, on a leaf change, the leaf
    logic sib_rd;     // read the sibling of the current tree node
    logic gcd_start;  // start the gcd of current node and sibling
    logic node_up;    // write the gcd into the parent and climb one level
    logic out_load;   // load the result register
  } mgt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;     // clearing pass is at its last entry
    logic is_update;    // captured operation is an insert or a remove
    logic leaf_change;  // count crossed between zero and one
    logic gcd_done;     // gcd unit has its result this cycle
    logic at_top;       // parent of the current node is the root
  } mgt_sts_t;

endpackage

@@ rtl/mgt_gcd.sv @@
// Iterative binary gcd unit, one subtract or shift step per cycle.
module mgt_gcd #(
  parameter int VALUE_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] a_i,
  input  logic [VALUE_BITS-1:0] b_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] gcd_o
);

  localparam int KW = $clog2(VALUE_BITS + 1);

  logic                  busy_q;
  logic [VALUE_BITS-1:0] a_q, b_q;
  logic [KW-1:0]         k_q;
  logic                  zero_hit;

  assign zero_hit = (a_q == '0) || (b_q == '0);
  assign done_o   = busy_q && zero_hit;
  // The common power of two is restored on the surviving operand.
  assign gcd_o    = (a_q | b_q) << k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      k_q <= '0;
    end else if (busy_q && !zero_hit) begin
      priority if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + KW'(1);
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q >= b_q) begin
        a_q <= (a_q - b_q) >> 1;
      end else begin
        b_q <= (b_q - a_q) >> 1;
      end
    end
  end

endmodule

@@ rtl/mgt_datapath.sv @@
// Datapath: count store, gcd tree store, node walk and result register.
module mgt_datapath #(
  parameter int VALUE_BITS = 10,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mgt_pkg::mgt_cmd_t     cmd_i,
  output mgt_pkg::mgt_sts_t     sts_o,
  input  logic [1:0]            in_op_i,
  input  logic [VALUE_BITS-1:0] in_value_i,
  output logic [VALUE_BITS-1:0] out_gcd_o,
  output logic                  out_ignored_o
);

  localparam int NODE_BITS  = VALUE_BITS + 1;
  localparam int LEAF_COUNT = 1 << VALUE_BITS;
  localparam int NODE_COUNT = 2 * LEAF_COUNT;

  logic [COUNT_BITS-1:0] cnt_mem [LEAF_COUNT];
  logic [VALUE_BITS-1:0] tree_mem [NODE_COUNT];

  logic [1:0]            op_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [VALUE_BITS-1:0] sib_rd_q;
  logic [NODE_BITS-1:0]  node_q;
  logic [VALUE_BITS-1:0] cur_q;
  logic                  flag_q;
  logic [NODE_BITS-1:0]  clr_q;
  logic [VALUE_BITS-1:0] root_q;
  logic [VALUE_BITS-1:0] gcd_q;
  logic                  ign_q;

  logic                  is_ins;
  logic                  flag_c;
  logic                  leaf_c;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [VALUE_BITS-1:0] leaf_val;
  logic [NODE_BITS-1:0]  parent;
  logic                  gcd_done;
  logic [VALUE_BITS-1:0] gcd_res;

  logic                  cnt_we;
  logic [VALUE_BITS-1:0] cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  tree_we;
  logic [NODE_BITS-1:0]  tree_waddr;
  logic [VALUE_BITS-1:0] tree_wdata;

  assign is_ins   = (op_q == mgt_pkg::OP_INSERT);
  assign flag_c   = is_ins ? (cnt_rd_q == '1) : (cnt_rd_q == '0);
  assign leaf_c   = !flag_c && (is_ins ? (cnt_rd_q == '0)
                                       : (cnt_rd_q == COUNT_BITS'(1)));
  assign cnt_new  = is_ins ? cnt_rd_q + COUNT_BITS'(1) : cnt_rd_q - COUNT_BITS'(1);
  assign leaf_val = is_ins ? val_q : '0;
  assign parent   = node_q >> 1;

  mgt_gcd #(
    .VALUE_BITS(VALUE_BITS)
  ) u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.gcd_start),
    .a_i    (cur_q),
    .b_i    (sib_rd_q),
    .done_o (gcd_done),
    .gcd_o  (gcd_res)
  );

  always_comb begin
    sts_o.clr_last    = &clr_q;
    sts_o.is_update   = (op_q == mgt_pkg::OP_INSERT) || (op_q == mgt_pkg::OP_REMOVE);
    sts_o.leaf_change = leaf_c;
    sts_o.gcd_done    = gcd_done;
    sts_o.at_top      = (node_q[NODE_BITS-1:1] == VALUE_BITS'(1));
  end

  // Write port selection for both stores.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = val_q;
    cnt_wdata = cnt_new;
    if (cmd_i.clr_step) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q[VALUE_BITS-1:0];
      cnt_wdata = '0;
    end else if (cmd_i.cnt_eval && !flag_c) begin
      cnt_we = 1'b1;
    end
  end

  always_comb begin
    tree_we    = 1'b0;
    tree_waddr = parent;
    tree_wdata = gcd_res;
    priority if (cmd_i.clr_step) begin
      tree_we    = 1'b1;
      tree_waddr = clr_q;
      tree_wdata = '0;
    end else if (cmd_i.cnt_eval && leaf_c) begin
      tree_we    = 1'b1;
      tree_waddr = {1'b1, val_q};
      tree_wdata = leaf_val;
    end else if (cmd_i.node_up) begin
      tree_we = 1'b1;
    end else begin
      tree_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cmd_i.cnt_rd) begin
      cnt_rd_q <= cnt_mem[val_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
    if (cmd_i.sib_rd) begin
      sib_rd_q <= tree_mem[node_q ^ NODE_BITS'(1)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      root_q <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + NODE_BITS'(1);
      end
      if (cmd_i.node_up && (parent == NODE_BITS'(1))) begin
        root_q <= gcd_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_op_i;
      val_q  <= in_value_i;
      flag_q <= 1'b0;
    end
    if (cmd_i.cnt_eval) begin
      flag_q <= flag_c;
      node_q <= {1'b1, val_q};
      cur_q  <= leaf_val;
    end
    if (cmd_i.node_up) begin
      node_q <= parent;
      cur_q  <= gcd_res;
    end
    if (cmd_i.out_load) begin
      gcd_q <= (root_q != '0) ? root_q : VALUE_BITS'(1);
      ign_q <= flag_q;
    end
  end

  assign out_gcd_o     = gcd_q;
  assign out_ignored_o = ign_q;

endmodule

@@ rtl/mgt_ctrl.sv @@
// Controller state machine sequencing clear pass, count update and tree walk.
module mgt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mgt_pkg::mgt_cmd_t cmd_o,
  input  mgt_pkg::mgt_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_EVAL,
    ST_SIB_RD,
    ST_GCD_START,
    ST_GCD_RUN,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   out_free;

  assign out_free    = !m_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = m_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.clr_step  = (state_q == ST_CLEAR);
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.cnt_rd    = (state_q == ST_CNT_RD);
    cmd_o.cnt_eval  = (state_q == ST_CNT_EVAL);
    cmd_o.sib_rd    = (state_q == ST_SIB_RD);
    cmd_o.gcd_start = (state_q == ST_GCD_START);
    cmd_o.node_up   = (state_q == ST_GCD_RUN) && sts_i.gcd_done;
    cmd_o.out_load  = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_CNT_RD;
        end
        ST_CNT_RD: begin
          state_q <= sts_i.is_update ? ST_CNT_EVAL : ST_OUT;
        end
        ST_CNT_EVAL: begin
          state_q <= sts_i.leaf_change ? ST_SIB_RD : ST_OUT;
        end
        ST_SIB_RD: begin
          state_q <= ST_GCD_START;
        end
        ST_GCD_START: begin
          state_q <= ST_GCD_RUN;
        end
        ST_GCD_RUN: begin
          if (sts_i.gcd_done) state_q <= sts_i.at_top ? ST_OUT : ST_SIB_RD;
        end
        ST_OUT: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Climbing a level only happens on a finished gcd.
  a_up_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.node_up |-> sts_i.gcd_done)
    else $error("tree node written before gcd finished");

  // The gcd unit only reports a result while the walk waits for it.
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.gcd_done |-> (state_q == ST_GCD_RUN))
    else $error("gcd result outside the tree walk");

  // A new result word only follows the output state.
  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result word raised outside output state");

endmodule

@@ rtl/multiset_gcd_tracker_core.sv @@
// Top level of the multiset gcd tracker: stream ports, controller and datapath.
// A query goes from accept through the count read to the result word; a refused or count-only
// update also passes the count update. A leaf change then walks VALUE_BITS levels of sibling
// read, gcd start and binary gcd, from the changed leaf up to the root.
// One word is worked at a time; a finished result waits in the output register.
// After reset a clearing pass over every tree entry zeroes both stores before tready rises.
module multiset_gcd_tracker_core #(
  parameter int VALUE_BITS = 10,
  parameter int COUNT_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input word stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // item_value, zero padded
  input  logic [1:0]                             s_axis_tuser,  // operation
  // Result word stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,  // set_gcd, zero padded
  output logic [0:0]                             m_axis_tuser   // ignored
);

  localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8;

  mgt_pkg::mgt_cmd_t     cmd;
  mgt_pkg::mgt_sts_t     sts;
  logic [VALUE_BITS-1:0] out_gcd;
  logic                  out_ignored;

  // The controller owns the handshakes and steps the datapath through the
  // count update and the walk from the changed leaf up to the root.
  mgt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // The datapath keeps the per-value copy counts, the heap-ordered gcd tree
  // and a copy of the root, so a word that changes no leaf needs no walk.
  mgt_datapath #(
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tuser),
    .in_value_i   (s_axis_tdata[VALUE_BITS-1:0]),
    .out_gcd_o    (out_gcd),
    .out_ignored_o(out_ignored)
  );

  assign m_axis_tdata = DATA_W'(out_gcd);
  assign m_axis_tuser = out_ignored;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the multiset gcd tracker core.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS = 10;
  localparam int COUNT_BITS = 16;
  localparam int DATA_W     = ((VALUE_BITS + 7) / 8) * 8;
  localparam int LEAVES     = 1 << VALUE_BITS;
  localparam int VALUE_MAX  = LEAVES - 1;
  localparam longint unsigned COUNT_CEIL = (64'd1 << COUNT_BITS) - 1;

  // The spare operation code behaves as a query.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Worst word: every tree level does a sibling read and a full binary gcd.
  localparam int SETTLE_CYCLES = VALUE_BITS * (2 * VALUE_BITS + 4) + 60;
  // Generous bound: clearing pass and every word at its slowest with the longest
  // stalls on both sides, taken several times over.
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [VALUE_BITS-1:0] set_gcd;
    logic                  ignored;
  } gcd_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;  // item_value, zero padded
  logic [1:0]        s_axis_tuser;  // operation
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;  // set_gcd, zero padded
  logic [0:0]        m_axis_tuser;  // ignored

  // Shadow copy of the block's state, kept in step with every accepted word.
  int unsigned           mset_counts [LEAVES];
  logic [VALUE_BITS-1:0] gcd_tree [2 * LEAVES];

  gcd_result_t expected_results[$];
  int          error_count = 0;
  int          cycle_count = 0;

  // Per-item wait ranges for each side; the test tasks change them by phase.
  int send_idle_max = 0;
  int recv_idle_max = 0;

  multiset_gcd_tracker_core #(
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Euclid on the value width; gcd(a, 0) is a.
  function automatic logic [VALUE_BITS-1:0] gcd_of(logic [VALUE_BITS-1:0] a,
                                                   logic [VALUE_BITS-1:0] b);
    logic [VALUE_BITS-1:0] r;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Writes one leaf and recombines every node on its path to the root.
  function automatic void write_leaf(logic [VALUE_BITS-1:0] v, logic [VALUE_BITS-1:0] leaf);
    int unsigned node;
    node = LEAVES + 32'(v);
    gcd_tree[node] = leaf;
    node = node >> 1;
    while (node >= 1) begin
      gcd_tree[node] = gcd_of(gcd_tree[2 * node], gcd_tree[2 * node + 1]);
      node = node >> 1;
    end
  endfunction

  // Applies one accepted word to the shadow state and queues the word it must produce.
  function automatic void track_word(logic [1:0] op, logic [VALUE_BITS-1:0] val);
    gcd_result_t res;
    res.ignored = 1'b0;
    if (op == mgt_pkg::OP_INSERT) begin
      if (mset_counts[val] >= COUNT_CEIL) begin
        res.ignored = 1'b1;
      end else begin
        mset_counts[val]++;
        if (mset_counts[val] == 1) write_leaf(val, val);
      end
    end else if (op == mgt_pkg::OP_REMOVE) begin
      if (mset_counts[val] == 0) begin
        res.ignored = 1'b1;
      end else begin
        mset_counts[val]--;
        if (mset_counts[val] == 0) write_leaf(val, '0);
      end
    end
    // An empty set, or one holding only zero, reports 1.
    res.set_gcd = (gcd_tree[1] != '0) ? gcd_tree[1] : VALUE_BITS'(1);
    expected_results.push_back(res);
  endfunction

  // Drives one word after a random gap and returns once it has been accepted.
  task automatic send_word(logic [1:0] op, logic [VALUE_BITS-1:0] val);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(DATA_W - VALUE_BITS){1'b0}}, val};
    s_axis_tuser  = op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_word(op, val);
  endtask

  // Result side: stalls a random number of cycles per word, then takes the next one.
  initial begin
    int          stall;
    gcd_result_t want;
    m_axis_tready = 1'b0;
    forever begin
      stall = $urandom_range(0, recv_idle_max);
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      if (expected_results.size() == 0) begin
        $display("%0t: result word with nothing expected, set_gcd %0d ignored %0d",
                 $time, m_axis_tdata[VALUE_BITS-1:0], m_axis_tuser[0]);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[VALUE_BITS-1:0] !== want.set_gcd) begin
          $display("%0t: set_gcd expected %0d actual %0d",
                   $time, want.set_gcd, m_axis_tdata[VALUE_BITS-1:0]);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.ignored) begin
          $display("%0t: ignored expected %0d actual %0d",
                   $time, want.ignored, m_axis_tuser[0]);
          error_count++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hand-picked words: empty set, refusals, value zero, the spare code, the widest
  // values, duplicates, and sets whose gcd shrinks and grows again as leaves clear.
  task automatic test_directed();
    send_idle_max = 3;
    recv_idle_max = 3;
    send_word(mgt_pkg::OP_QUERY,  10'd0);
    send_word(mgt_pkg::OP_REMOVE, 10'd5);      // absent value is refused
    send_word(mgt_pkg::OP_INSERT, 10'd0);      // zero leaf leaves the gcd at 1
    send_word(OP_SPARE,           10'd1023);
    send_word(mgt_pkg::OP_INSERT, 10'd1023);
    send_word(mgt_pkg::OP_INSERT, 10'd1023);   // second copy, count only
    send_word(mgt_pkg::OP_INSERT, 10'd682);    // gcd 341
    send_word(mgt_pkg::OP_QUERY,  10'd1023);
    send_word(mgt_pkg::OP_INSERT, 10'd512);
    send_word(mgt_pkg::OP_REMOVE, 10'd512);
    send_word(mgt_pkg::OP_REMOVE, 10'd1023);
    send_word(mgt_pkg::OP_REMOVE, 10'd1023);   // last copy, leaf clears
    send_word(mgt_pkg::OP_REMOVE, 10'd1023);
    send_word(mgt_pkg::OP_INSERT, 10'd768);
    send_word(mgt_pkg::OP_INSERT, 10'd256);
    send_word(mgt_pkg::OP_REMOVE, 10'd682);
    send_word(mgt_pkg::OP_INSERT, 10'd1);
    send_word(mgt_pkg::OP_REMOVE, 10'd1);
    send_word(mgt_pkg::OP_REMOVE, 10'd768);
    send_word(mgt_pkg::OP_REMOVE, 10'd256);
    send_word(mgt_pkg::OP_REMOVE, 10'd0);
    send_word(mgt_pkg::OP_REMOVE, 10'd0);
    send_word(OP_SPARE,           10'd0);
  endtask

  // Stacks many copies of one value with no idling, so that only the first insert and
  // the last remove touch the tree, then checks that one more remove is refused.
  task automatic test_duplicates();
    send_idle_max = 0;
    recv_idle_max = 0;
    repeat (16) send_word(mgt_pkg::OP_INSERT, 10'd6);
    send_word(mgt_pkg::OP_INSERT, 10'd9);      // gcd 3
    repeat (16) send_word(mgt_pkg::OP_REMOVE, 10'd6);
    send_word(mgt_pkg::OP_REMOVE, 10'd6);      // no copy left, refused
    send_word(mgt_pkg::OP_REMOVE, 10'd9);
  endtask

  // Phases of inserts and removes drawn from the multiples of one base, so that the
  // gcd stays above 1 for a while, mixed with queries and unrelated words. Each phase
  // ends by removing the values of its base-multiple inserts, but not those of unrelated words.
  task automatic test_random_sets(int phases, int words_per_phase);
    int unsigned           held[$];
    int unsigned           base;
    int unsigned           pick;
    int unsigned           slot;
    logic [VALUE_BITS-1:0] val;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 3))
        0: begin
          send_idle_max = 0;
          recv_idle_max = 0;
        end
        1: begin
          send_idle_max = 12;
          recv_idle_max = 0;
        end
        2: begin
          send_idle_max = 0;
          recv_idle_max = 12;
        end
        default: begin
          send_idle_max = 12;
          recv_idle_max = 12;
        end
      endcase
      base = ($urandom_range(0, 1) != 0) ? (1 << $urandom_range(0, 6)) :
                                          $urandom_range(1, 60);
      for (int i = 0; i < words_per_phase; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45 || (pick < 75 && held.size() == 0)) begin
          val = VALUE_BITS'($urandom_range(0, VALUE_MAX / base) * base);
          held.push_back(32'(val));
          send_word(mgt_pkg::OP_INSERT, val);
        end else if (pick < 75) begin
          slot = $urandom_range(0, held.size() - 1);
          val  = VALUE_BITS'(held[slot]);
          held.delete(slot);
          send_word(mgt_pkg::OP_REMOVE, val);
        end else if (pick < 85) begin
          send_word(($urandom_range(0, 1) != 0) ? mgt_pkg::OP_QUERY : OP_SPARE,
                    VALUE_BITS'($urandom_range(0, VALUE_MAX)));
        end else begin
          send_word(2'($urandom_range(0, 3)), VALUE_BITS'($urandom_range(0, VALUE_MAX)));
        end
      end
      while (held.size() != 0) begin
        slot = $urandom_range(0, held.size() - 1);
        val  = VALUE_BITS'(held[slot]);
        held.delete(slot);
        send_word(mgt_pkg::OP_REMOVE, val);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < LEAVES; i++) mset_counts[i] = 0;
    for (int i = 0; i < 2 * LEAVES; i++) gcd_tree[i] = '0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = mgt_pkg::OP_QUERY;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The block clears its stores first; send_word simply waits for tready.
    test_directed();
    test_duplicates();
    test_random_sets(6, 80);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ multiset_gcd_tracker_core.f @@
rtl/mgt_pkg.sv
rtl/mgt_gcd.sv
rtl/mgt_datapath.sv
rtl/mgt_ctrl.sv
rtl/multiset_gcd_tracker_core.sv
sim/tb_top.sv
